// ===== hw/rtl/sfla_pkg.sv =====
package sfla_pkg;

  // request function codes
  localparam logic [2:0] FUNC_WRITE  = 3'd0;
  localparam logic [2:0] FUNC_ADD    = 3'd1;
  localparam logic [2:0] FUNC_REMOVE = 3'd2;
  localparam logic [2:0] FUNC_CLEAR  = 3'd3;
  localparam logic [2:0] FUNC_EVAL   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_BIAS    = 2'd0;
  localparam logic [1:0] CFG_LOW_THR = 2'd1;
  localparam logic [1:0] CFG_MID_THR = 2'd2;

  // bucket codes
  localparam logic [1:0] BUCKET_LOW  = 2'd0;
  localparam logic [1:0] BUCKET_MID  = 2'd1;
  localparam logic [1:0] BUCKET_HIGH = 2'd2;

  // register reset values
  localparam logic signed [31:0] BIAS_RESET    = 32'sd0;
  localparam logic signed [33:0] LOW_THR_RESET = -34'sd9000;
  localparam logic signed [33:0] MID_THR_RESET = -34'sd1644;

  // saturation limits of a side sum
  localparam logic signed [31:0] SUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

  // result queue geometry
  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;
  localparam int QCW    = QAW + 1;

  typedef struct packed {
    logic [2:0]         func;
    logic               side;
    logic [16:0]        feature_index;
    logic signed [15:0] weight_value;
  } req_t;

  typedef struct packed {
    logic signed [33:0] twice_logit;
    logic [1:0]         bucket;
  } rsp_t;

  // control of one request entering the accumulate stage
  typedef struct packed {
    logic       valid;
    logic [2:0] func;
    logic       side;
    logic       in_range;
  } op_t;

  // evaluate sum leaving the accumulate stage
  typedef struct packed {
    logic               valid;
    logic signed [33:0] twice;
  } eval_t;

endpackage

// ===== hw/rtl/sfla_ram.sv =====
module sfla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/sfla_accum.sv =====
module sfla_accum (
  input  logic                clk,
  input  logic                rst,
  input  sfla_pkg::op_t       op,
  input  logic signed [15:0]  weight,
  input  logic signed [31:0]  bias,
  output sfla_pkg::eval_t     eval
);

  sfla_pkg::op_t      s1;
  logic signed [31:0] sums      [2];
  logic signed [31:0] sums_next [2];
  logic signed [31:0] sel_sum;
  logic signed [32:0] total;
  logic signed [31:0] sat_sum;
  logic signed [33:0] twice;

  // stage register alongside the table read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= op;
    end
  end

  // add or subtract the weight, clamp to 32 bits
  always_comb begin
    sel_sum = sums[s1.side];
    if (s1.func == sfla_pkg::FUNC_REMOVE) begin
      total = {sel_sum[31], sel_sum} - {{17{weight[15]}}, weight};
    end else begin
      total = {sel_sum[31], sel_sum} + {{17{weight[15]}}, weight};
    end
    if (total[32] != total[31]) begin
      sat_sum = total[32] ? sfla_pkg::SUM_MIN : sfla_pkg::SUM_MAX;
    end else begin
      sat_sum = total[31:0];
    end
  end

  // side sum update
  always_comb begin
    sums_next = sums;
    if (s1.valid) begin
      case (s1.func) inside
        sfla_pkg::FUNC_ADD, sfla_pkg::FUNC_REMOVE: begin
          if (s1.in_range) begin
            sums_next[s1.side] = sat_sum;
          end
        end
        sfla_pkg::FUNC_CLEAR: begin
          sums_next[s1.side] = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums[0] <= '0;
      sums[1] <= '0;
    end else begin
      sums <= sums_next;
    end
  end

  // twice the logit: 2*bias plus both sides
  assign twice = {bias[31], bias, 1'b0}
               + {{2{sums[0][31]}}, sums[0]}
               + {{2{sums[1][31]}}, sums[1]};

  always_ff @(posedge clk) begin
    eval.twice <= twice;
    if (rst) begin
      eval.valid <= 1'b0;
    end else begin
      eval.valid <= s1.valid && (s1.func == sfla_pkg::FUNC_EVAL);
    end
  end

endmodule

// ===== hw/rtl/sfla_result.sv =====
module sfla_result (
  input  logic                        clk,
  input  logic                        rst,
  input  sfla_pkg::eval_t             eval,
  input  logic signed [33:0]          low_thr,
  input  logic signed [33:0]          mid_thr,
  input  logic                        rsp_stall,
  output logic                        rsp_valid,
  output sfla_pkg::rsp_t              rsp,
  output logic [sfla_pkg::QCW-1:0]    count
);

  sfla_pkg::rsp_t             q [sfla_pkg::QDEPTH];
  sfla_pkg::rsp_t             entry;
  logic [sfla_pkg::QAW-1:0]   wr_ptr;
  logic [sfla_pkg::QAW-1:0]   rd_ptr;
  logic                       push;
  logic                       pop;

  // bucket from the two thresholds
  always_comb begin
    entry.twice_logit = eval.twice;
    if (eval.twice < low_thr) begin
      entry.bucket = sfla_pkg::BUCKET_LOW;
    end else if (eval.twice < mid_thr) begin
      entry.bucket = sfla_pkg::BUCKET_MID;
    end else begin
      entry.bucket = sfla_pkg::BUCKET_HIGH;
    end
  end

  assign push      = eval.valid;
  assign pop       = rsp_valid && !rsp_stall;
  assign rsp_valid = (count != '0);
  assign rsp       = q[rd_ptr];

  // result queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // upstream credit check must keep the queue from overflowing
  assert property (@(posedge clk) disable iff (rst)
    push |-> (count < sfla_pkg::QCW'(sfla_pkg::QDEPTH)) || pop)
    else $error("result queue overflow");

  // a queued result never carries an unused bucket code
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.bucket == sfla_pkg::BUCKET_LOW) || (rsp.bucket == sfla_pkg::BUCKET_MID)
                  || (rsp.bucket == sfla_pkg::BUCKET_HIGH))
    else $error("bad bucket in result queue");
`endif

endmodule

// ===== hw/rtl/sparse_feature_linear_accumulator_core.sv =====
// path: an evaluate request passes the table read stage, the accumulate/sum
// stage and the bucket compare into the result queue
// throughput: one request per cycle while not stalled; requests stall only in
// reset or when in-flight evaluates plus the 4-entry result queue reach 4 entries
// reset: synchronous; clears side sums, pipeline valids and queue, loads register
// defaults; the weight table is not cleared and holds garbage until written
module sparse_feature_linear_accumulator_core #(
  parameter int NUM_FEATURES = 131072
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  sfla_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output sfla_pkg::rsp_t   rsp,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [33:0]      cfg_data
);

  localparam int AW = $clog2(NUM_FEATURES);
  localparam logic [20:0] FEAT_LIMIT = 21'(NUM_FEATURES);

  logic signed [31:0]       bias;
  logic signed [33:0]       low_thr;
  logic signed [33:0]       mid_thr;
  logic                     accept;
  logic                     in_range;
  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [15:0]              ram_rdata;
  sfla_pkg::op_t            op;
  sfla_pkg::eval_t          eval;
  logic [sfla_pkg::QCW-1:0] qcount;
  logic [1:0]               inflight;
  logic [1:0]               inflight_next;
  logic                     eval_enter;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bias    <= sfla_pkg::BIAS_RESET;
      low_thr <= sfla_pkg::LOW_THR_RESET;
      mid_thr <= sfla_pkg::MID_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfla_pkg::CFG_BIAS:    bias    <= cfg_data[31:0];
        sfla_pkg::CFG_LOW_THR: low_thr <= cfg_data;
        sfla_pkg::CFG_MID_THR: mid_thr <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request acceptance and table access
  assign accept   = req_valid && !req_stall;
  assign in_range = {4'd0, req.feature_index} < FEAT_LIMIT;
  assign ram_we   = accept && (req.func == sfla_pkg::FUNC_WRITE) && in_range;
  assign ram_addr = AW'(req.feature_index);

  sfla_ram #(
    .WIDTH (16),
    .DEPTH (NUM_FEATURES)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req.weight_value),
    .rdata (ram_rdata)
  );

  assign op.valid    = accept;
  assign op.func     = req.func;
  assign op.side     = req.side;
  assign op.in_range = in_range;

  sfla_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .weight ($signed(ram_rdata)),
    .bias   (bias),
    .eval   (eval)
  );

  sfla_result u_result (
    .clk       (clk),
    .rst       (rst),
    .eval      (eval),
    .low_thr   (low_thr),
    .mid_thr   (mid_thr),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .count     (qcount)
  );

  // evaluates between acceptance and the result queue
  assign eval_enter = accept && (req.func == sfla_pkg::FUNC_EVAL);

  always_comb begin
    inflight_next = inflight;
    if (eval_enter && !eval.valid) begin
      inflight_next = inflight + 1'b1;
    end else if (!eval_enter && eval.valid) begin
      inflight_next = inflight - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  // hold requests when queue space could run out
  assign req_stall = rst ||
    ((sfla_pkg::QCW'(inflight) + qcount) >= sfla_pkg::QCW'(sfla_pkg::QDEPTH));

`ifndef SYNTHESIS
  // an accepted evaluate reaches the result queue after the table read and accumulate registers
  assert property (@(posedge clk) disable iff (rst)
    eval_enter |-> ##2 eval.valid)
    else $error("evaluate request lost in pipeline");

  // nothing reaches the result queue without an evaluate request
  assert property (@(posedge clk) disable iff (rst)
    eval.valid |-> $past(eval_enter, 2))
    else $error("result without evaluate request");
`endif

endmodule

// ===== tb/sfla_checker.sv =====
`timescale 1ns / 100ps

module sfla_checker #(
  parameter int NUM_FEATURES = 131072
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  sfla_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  sfla_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [33:0]    cfg_data,
  output int             mismatches,
  output int             logits_outstanding,
  output int             logits_checked
);

  localparam int MAX_REPORTS = 20;

  // shadow copy of the weight table, side sums and registers
  logic signed [15:0] weight_mem [int];
  logic signed [31:0] side_sum [2];
  logic signed [31:0] bias_scaled;
  logic signed [33:0] low_thr;
  logic signed [33:0] mid_thr;
  sfla_pkg::rsp_t     expected_logits [$];

  // clamp a widened side sum to the signed 32-bit range
  function automatic logic signed [31:0] clamp_sum(input longint v);
    longint hi;
    longint lo;
    hi = sfla_pkg::SUM_MAX;
    lo = sfla_pkg::SUM_MIN;
    if (v > hi) return sfla_pkg::SUM_MAX;
    if (v < lo) return sfla_pkg::SUM_MIN;
    return v[31:0];
  endfunction

  // twice the logit and its bucket from the current shadow state
  function automatic sfla_pkg::rsp_t predict_logit();
    sfla_pkg::rsp_t p;
    longint b;
    longint s0;
    longint s1;
    longint twice;
    longint lo;
    longint mid;
    b = bias_scaled;
    s0 = side_sum[0];
    s1 = side_sum[1];
    lo = low_thr;
    mid = mid_thr;
    twice = 2 * b + s0 + s1;
    p.twice_logit = twice[33:0];
    if (twice < lo) begin
      p.bucket = sfla_pkg::BUCKET_LOW;
    end else if (twice < mid) begin
      p.bucket = sfla_pkg::BUCKET_MID;
    end else begin
      p.bucket = sfla_pkg::BUCKET_HIGH;
    end
    return p;
  endfunction

  // update the shadow state for one accepted request
  task automatic apply_request(input sfla_pkg::req_t r);
    logic signed [15:0] w;
    longint             acc;
    bit                 in_range;
    in_range = r.feature_index < NUM_FEATURES;
    w = '0;
    if (in_range && weight_mem.exists(int'(r.feature_index))) begin
      w = weight_mem[int'(r.feature_index)];
    end
    acc = side_sum[r.side];
    case (r.func)
      sfla_pkg::FUNC_WRITE: begin
        if (in_range) weight_mem[int'(r.feature_index)] = r.weight_value;
      end
      sfla_pkg::FUNC_ADD: begin
        if (in_range) side_sum[r.side] = clamp_sum(acc + w);
      end
      sfla_pkg::FUNC_REMOVE: begin
        if (in_range) side_sum[r.side] = clamp_sum(acc - w);
      end
      sfla_pkg::FUNC_CLEAR: begin
        side_sum[r.side] = '0;
      end
      sfla_pkg::FUNC_EVAL: begin
        expected_logits.push_back(predict_logit());
      end
      default: ;
    endcase
  endtask

  // compare one delivered result with the oldest prediction
  task automatic check_logit(input sfla_pkg::rsp_t got);
    sfla_pkg::rsp_t want;
    logits_checked++;
    if (expected_logits.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: unexpected result, twice_logit %0d bucket %0d", $time,
                 got.twice_logit, got.bucket);
      end
      return;
    end
    want = expected_logits.pop_front();
    if (got.twice_logit !== want.twice_logit) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: twice_logit expected %0d got %0d", $time,
                 want.twice_logit, got.twice_logit);
      end
    end
    if (got.bucket !== want.bucket) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: bucket expected %0d got %0d (twice_logit %0d)", $time,
                 want.bucket, got.bucket, want.twice_logit);
      end
    end
  endtask

  // watch configuration, request and result channels
  always @(posedge clk) begin
    if (rst) begin
      weight_mem.delete();
      expected_logits.delete();
      side_sum[0] = '0;
      side_sum[1] = '0;
      bias_scaled = sfla_pkg::BIAS_RESET;
      low_thr = sfla_pkg::LOW_THR_RESET;
      mid_thr = sfla_pkg::MID_THR_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfla_pkg::CFG_BIAS:    bias_scaled = cfg_data[31:0];
          sfla_pkg::CFG_LOW_THR: low_thr = cfg_data;
          sfla_pkg::CFG_MID_THR: mid_thr = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) apply_request(req);
      if (rsp_valid && !rsp_stall) check_logit(rsp);
    end
    logits_outstanding = expected_logits.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_FEATURES = 131072;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int NUM_SETTINGS = 6;
  localparam int SETTLE       = 6;

  localparam logic signed [33:0] BIAS_MAX = 34'sh0_7fff_ffff;
  localparam logic signed [33:0] BIAS_MIN = -34'sd2147483648;
  localparam logic signed [33:0] THR_MAX  = {1'b0, {33{1'b1}}};
  localparam logic signed [33:0] THR_MIN  = {1'b1, 33'd0};

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  sfla_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_stall;
  sfla_pkg::rsp_t rsp;
  logic           cfg_we;
  logic [1:0]     cfg_index;
  logic [33:0]    cfg_data;

  int mismatches;
  int logits_outstanding;
  int logits_checked;

  int cycle_count = 0;
  int requests_sent = 0;
  int noise_sent = 0;
  int settings_applied = 0;
  bit quiet = 1'b0;

  // indexes loaded so far; adds and removes only read these
  int written_list [$];
  bit written_flag [int];

  sparse_feature_linear_accumulator_core #(
    .NUM_FEATURES(NUM_FEATURES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  sfla_checker #(
    .NUM_FEATURES(NUM_FEATURES)
  ) u_checker (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .req               (req),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .rsp               (rsp),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .logits_outstanding(logits_outstanding),
    .logits_checked    (logits_checked)
  );

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int p;
    p = $urandom_range(99);
    if (p < 75) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int req_gap();
    if (quiet) return 0;
    if ($urandom_range(99) < 65) return 0;
    return idle_len();
  endfunction

  // result side back-pressure in runs
  initial begin : rsp_backpressure
    int run_left;
    bit hold;
    run_left = 0;
    hold = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        hold = !quiet && ($urandom_range(99) < 30);
        run_left = hold ? idle_len() : $urandom_range(1, 12);
      end
      run_left--;
      rsp_stall <= hold;
    end
  end

  // request with every field random; callers override what matters
  function automatic sfla_pkg::req_t noisy(input logic [2:0] f);
    sfla_pkg::req_t r;
    r.func = f;
    r.side = 1'($urandom_range(1));
    r.feature_index = 17'($urandom_range(NUM_FEATURES - 1));
    r.weight_value = 16'($urandom());
    return r;
  endfunction

  function automatic logic signed [15:0] rand_weight();
    int p;
    p = $urandom_range(99);
    if (p < 15) return 16'sh7fff;
    if (p < 30) return 16'sh8000;
    if (p < 60) return 16'(int'($urandom_range(4000)) - 2000);
    return 16'($urandom());
  endfunction

  function automatic logic [16:0] pick_written();
    return 17'(written_list[$urandom_range(written_list.size() - 1)]);
  endfunction

  // drive one request and hold it until accepted
  task automatic push_request(input sfla_pkg::req_t r);
    int gap;
    @(negedge clk);
    gap = req_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    requests_sent++;
    if (r.func > sfla_pkg::FUNC_EVAL) noise_sent++;
  endtask

  task automatic do_write(input logic [16:0] idx, input logic signed [15:0] w);
    sfla_pkg::req_t r;
    r = noisy(sfla_pkg::FUNC_WRITE);
    r.feature_index = idx;
    r.weight_value = w;
    push_request(r);
    if (!written_flag.exists(int'(idx))) begin
      written_flag[int'(idx)] = 1'b1;
      written_list.push_back(int'(idx));
    end
  endtask

  task automatic do_update(input logic [2:0] f, input logic s, input logic [16:0] idx);
    sfla_pkg::req_t r;
    r = noisy(f);
    r.side = s;
    r.feature_index = idx;
    push_request(r);
  endtask

  task automatic do_clear(input logic s);
    sfla_pkg::req_t r;
    r = noisy(sfla_pkg::FUNC_CLEAR);
    r.side = s;
    push_request(r);
  endtask

  task automatic do_eval();
    push_request(noisy(sfla_pkg::FUNC_EVAL));
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [33:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_registers(input logic signed [33:0] bias,
                               input logic signed [33:0] lo,
                               input logic signed [33:0] mid);
    write_cfg(sfla_pkg::CFG_BIAS, bias);
    write_cfg(sfla_pkg::CFG_LOW_THR, lo);
    write_cfg(sfla_pkg::CFG_MID_THR, mid);
    settings_applied++;
  endtask

  // stop sending, wait out every expected result and the pipeline
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (logits_outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apply_setting(input int k);
    logic [63:0] raw;
    logic [63:0] raw2;
    raw = {$urandom(), $urandom()};
    raw2 = {$urandom(), $urandom()};
    case (k)
      0: set_registers(BIAS_MAX, THR_MIN, THR_MAX);
      1: set_registers(BIAS_MIN, THR_MAX, THR_MIN);
      2: set_registers('0, -34'sd20000, 34'sd20000);
      3: set_registers(34'(int'($urandom_range(100000)) - 50000),
                       34'(int'($urandom_range(400000)) - 200000),
                       34'(int'($urandom_range(400000)) - 200000));
      4: set_registers(34'($signed(raw[31:0])), raw[63:30], raw2[33:0]);
      default: set_registers('0, '0, '0);
    endcase
  endtask

  // well-formed update sequences with random content, plus some noise
  task automatic random_traffic(input int target);
    int   start;
    int   kind;
    logic s;
    logic [16:0] idx;
    start = requests_sent - noise_sent;
    while (requests_sent - noise_sent - start < target) begin
      kind = $urandom_range(99);
      s = 1'($urandom_range(1));
      if (kind < 35) begin
        // incremental move: drop some features, add others
        repeat ($urandom_range(1, 3)) do_update(sfla_pkg::FUNC_REMOVE, s, pick_written());
        repeat ($urandom_range(1, 3)) do_update(sfla_pkg::FUNC_ADD, s, pick_written());
        do_eval();
      end else if (kind < 55) begin
        // full recompute of one side
        do_clear(s);
        repeat ($urandom_range(2, 8)) do_update(sfla_pkg::FUNC_ADD, s, pick_written());
        do_eval();
      end else if (kind < 72) begin
        repeat ($urandom_range(1, 4)) do_write(17'($urandom_range(NUM_FEATURES - 1)),
                                               rand_weight());
      end else if (kind < 82) begin
        // read right behind the write of the same entry
        idx = 17'($urandom_range(NUM_FEATURES - 1));
        do_write(idx, rand_weight());
        do_update($urandom_range(1) ? sfla_pkg::FUNC_ADD : sfla_pkg::FUNC_REMOVE, s, idx);
        do_eval();
      end else if (kind < 92) begin
        do_update($urandom_range(1) ? sfla_pkg::FUNC_ADD : sfla_pkg::FUNC_REMOVE, s,
                  pick_written());
        do_eval();
      end else if (kind < 97) begin
        push_request(noisy(3'($urandom_range(5, 7))));
      end else begin
        do_clear(s);
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    int k;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sfla_pkg::CFG_BIAS;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, every function, register defaults
    do_write(17'h00000, 16'sh7fff);
    do_write(17'h1ffff, 16'sh8000);
    do_write(17'h15555, -16'sd1);
    do_write(17'h0aaaa, 16'sd1);
    do_eval();
    do_update(sfla_pkg::FUNC_ADD, 1'b0, 17'h00000);
    do_update(sfla_pkg::FUNC_ADD, 1'b1, 17'h1ffff);
    do_eval();
    do_update(sfla_pkg::FUNC_REMOVE, 1'b1, 17'h00000);
    do_eval();
    do_clear(1'b1);
    do_update(sfla_pkg::FUNC_REMOVE, 1'b0, 17'h1ffff);
    do_update(sfla_pkg::FUNC_ADD, 1'b0, 17'h15555);
    do_eval();
    push_request(noisy(3'd5));
    push_request(noisy(3'd6));
    push_request(noisy(3'd7));
    do_eval();
    do_clear(1'b0);
    do_write(17'h0aaaa, -16'sd3000);
    do_update(sfla_pkg::FUNC_ADD, 1'b0, 17'h0aaaa);
    do_eval();
    drain();

    // random traffic over several register settings
    for (k = 0; k < NUM_SETTINGS; k++) begin
      apply_setting(k);
      quiet = (k == 2);
      random_traffic(RANDOM_ITEMS / NUM_SETTINGS);
      drain();
    end

    $display("%0d requests (%0d with unused codes), %0d results checked, %0d register settings",
             requests_sent, noise_sent, logits_checked, settings_applied);
    $display("incremental and recompute updates under random gaps and stalls, extreme registers");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sfla_pkg.sv
hw/rtl/sfla_ram.sv
hw/rtl/sfla_accum.sv
hw/rtl/sfla_result.sv
hw/rtl/sparse_feature_linear_accumulator_core.sv
tb/sfla_checker.sv
tb/tb_top.sv
